### hdl/dmpd_pkg.sv
// ----------------------------------------------------------------------------
// dmpd_pkg
// Shared types, constants and the inner-wheel ratio table of the
// differential motor PWM drive.
// ----------------------------------------------------------------------------
`default_nettype none

package dmpd_pkg;

	// Inner-wheel ratio table: depth and index width
	localparam int RATIO_ENTRIES = 46;
	localparam int IDX_W         = (RATIO_ENTRIES > 1) ? $clog2(RATIO_ENTRIES) : 1;
	localparam int RATIO_HEAD_N  = 30;
	localparam logic [6:0] RATIO_FAR = 7'd60;
	localparam logic [6:0] RATIO_HEAD [RATIO_HEAD_N] = '{
		7'd100, 7'd98, 7'd97, 7'd95, 7'd93,
		7'd92,  7'd90, 7'd88, 7'd87, 7'd85,
		7'd84,  7'd82, 7'd81, 7'd79, 7'd78,
		7'd76,  7'd75, 7'd73, 7'd72, 7'd71,
		7'd69,  7'd68, 7'd66, 7'd65, 7'd64,
		7'd62,  7'd61, 7'd60, 7'd60, 7'd60
	};

	// APB address width: three 32-bit registers at 0, 4, 8
	localparam int ADDR_W = 4;

	// Angle / 3 for magnitudes up to 256: (x * 171) >> 9
	localparam logic [7:0] DIV3_MUL   = 8'd171;
	localparam int         DIV3_SHIFT = 9;

	// Exact floor(p / 100) for p < 2**PROD_W: (p * ceil(2**31 / 100)) >> 31
	localparam int              PROD_W       = 24;
	localparam int              QUOT_W       = 18;
	localparam int              DIV100_SHIFT = 31;
	localparam longint unsigned PCT_DIV      = 100;
	localparam logic [24:0]     DIV100_MUL   =
		25'(((64'd1 << DIV100_SHIFT) + PCT_DIV - 64'd1) / PCT_DIV);

	typedef struct packed {
		logic [6:0]  max_speed_percent;
		logic [15:0] motor_pwm_period;
		logic [15:0] servo_center_count;
	} cfg_t;

	// Request to the shared multiply / divide-by-100 unit
	typedef struct packed {
		logic        issue;
		logic [8:0]  a;   // signed operand, two's complement
		logic [15:0] b;   // unsigned operand
	} md_req_t;

	typedef struct packed {
		logic              neg;
		logic [QUOT_W-1:0] quot;
	} md_rsp_t;

	function automatic logic [6:0] ratio_lookup(input logic [IDX_W-1:0] idx);
		logic [8:0] w;
		w = 9'(idx);
		if (w < 9'(RATIO_HEAD_N)) begin
			return RATIO_HEAD[w[4:0]];
		end
		return RATIO_FAR;
	endfunction

endpackage

`default_nettype wire

### hdl/dmpd_cmd_if.sv
// ----------------------------------------------------------------------------
// dmpd_cmd_if
// Command channel: one control-period item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmpd_cmd_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] throttle;
	logic              turn_right;
	logic signed [8:0] steer_angle;
	logic              clear_trip;

	modport source (output valid, throttle, turn_right, steer_angle, clear_trip,
		input ready);
	modport sink (input valid, throttle, turn_right, steer_angle, clear_trip,
		output ready);
endinterface

`default_nettype wire

### hdl/dmpd_res_if.sv
// ----------------------------------------------------------------------------
// dmpd_res_if
// Result channel: wheel compares, servo compare and trip distance.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmpd_res_if;
	logic        valid;
	logic        ready;
	logic        left_reverse;
	logic [15:0] left_compare;
	logic        right_reverse;
	logic [15:0] right_compare;
	logic [15:0] servo_compare;
	logic [31:0] trip_distance;

	modport source (output valid, left_reverse, left_compare, right_reverse,
		right_compare, servo_compare, trip_distance, input ready);
	modport sink (input valid, left_reverse, left_compare, right_reverse,
		right_compare, servo_compare, trip_distance, output ready);
endinterface

`default_nettype wire

### hdl/differential_motor_pwm_drive.sv
// ----------------------------------------------------------------------------
// differential_motor_pwm_drive
// Differential-steering motor PWM drive with trip odometer: a step sequencer
// runs five multiply / divide-by-100 jobs through one shared unit per item.
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    throttle, turn_right, steer_angle, clear_trip
//   res      out  valid/ready    left/right reverse+compare, servo, trip
//   apb      in   psel/penable   max speed %, PWM period, servo center
//
// An item holds the block busy from its accept through the steps inner to
// done, and no new item is taken until it is through. The busy span is set
// by the latency of the shared unit over the chain inner -> wheel -> compare.
// Reset clears the trip sums and loads the register defaults at once.
// The last step holds while the output register still carries an untaken item;
// a finished item waiting there does not block the next accept.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_motor_pwm_drive (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	dmpd_cmd_if.sink                         cmd,
	dmpd_res_if.source                       res,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [dmpd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	localparam logic [2:0] STEP_INNER = 3'd0;
	localparam logic [2:0] STEP_LEFT  = 3'd2;
	localparam logic [2:0] STEP_RIGHT = 3'd3;
	localparam logic [2:0] STEP_LCMP  = 3'd4;
	localparam logic [2:0] STEP_RCMP  = 3'd5;
	localparam logic [2:0] STEP_TRIP  = 3'd6;
	localparam logic [2:0] STEP_DONE  = 3'd7;

	dmpd_pkg::cfg_t    cfg;
	dmpd_pkg::md_req_t md_req;
	dmpd_pkg::md_rsp_t md_rsp;

	logic       state_q;
	logic [2:0] step_q;

	logic       cmd_acc;
	logic [8:0] ang_bits;
	logic [8:0] ang_abs;
	logic [16:0] div3_prod;
	logic [8:0] idx_raw;
	logic [8:0] idx_clamp;
	logic [dmpd_pkg::IDX_W-1:0] idx;

	logic [7:0]  thr_q;
	logic        turn_q;
	logic        clr_q;
	logic [6:0]  ratio_q;
	logic [15:0] servo_q;
	logic [8:0]  inner_q;
	logic [8:0]  left_q;
	logic [8:0]  right_q;
	logic [15:0] lcmp_q;
	logic [31:0] left_sum_q;
	logic [31:0] right_sum_q;

	logic [8:0]  thr9;
	logic [8:0]  rsp_val;
	logic [15:0] cmp_sat;
	logic [15:0] pm1;
	logic        out_free;
	logic        out_load;

	logic        left_pos;
	logic        right_pos;
	logic [31:0] lsum_base;
	logic [31:0] rsum_base;
	logic [32:0] lsum_add;
	logic [32:0] rsum_add;
	logic [31:0] lsum_next;
	logic [31:0] rsum_next;
	logic [32:0] trip_total;

	logic        res_valid_q;
	logic        res_lrev_q;
	logic [15:0] res_lcmp_q;
	logic        res_rrev_q;
	logic [15:0] res_rcmp_q;
	logic [15:0] res_servo_q;
	logic [31:0] res_trip_q;

	dmpd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dmpd_muldiv u_muldiv (
		.clk (clk),
		.req (md_req),
		.rsp (md_rsp)
	);

	// Accept side: ratio index and servo compare
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign ang_bits  = cmd.steer_angle;
	assign ang_abs   = ang_bits[8] ? 9'(-ang_bits) : ang_bits;
	assign div3_prod = 17'(ang_abs) * 17'(dmpd_pkg::DIV3_MUL);
	assign idx_raw   = 9'(div3_prod[16:dmpd_pkg::DIV3_SHIFT]);
	assign idx_clamp = (idx_raw > 9'(dmpd_pkg::RATIO_ENTRIES - 1)) ?
		9'(dmpd_pkg::RATIO_ENTRIES - 1) : idx_raw;
	assign idx       = dmpd_pkg::IDX_W'(idx_clamp);

	// Shared-unit operands and answers
	assign thr9    = {thr_q[7], thr_q};
	assign rsp_val = md_rsp.neg ? 9'(-md_rsp.quot[8:0]) : md_rsp.quot[8:0];
	assign cmp_sat = (|md_rsp.quot[dmpd_pkg::QUOT_W-1:16]) ? 16'hFFFF :
		md_rsp.quot[15:0];
	assign pm1     = (cfg.motor_pwm_period == 16'd0) ? 16'd0 :
		16'(cfg.motor_pwm_period - 16'd1);

	always_comb begin
		md_req = '0;
		if (state_q == ST_BUSY) begin
			unique case (step_q)
				STEP_INNER: begin
					md_req.issue = 1'b1;
					md_req.a     = thr9;
					md_req.b     = 16'(ratio_q);
				end
				STEP_LEFT: begin
					md_req.issue = 1'b1;
					md_req.a     = turn_q ? thr9 : rsp_val;
					md_req.b     = 16'(cfg.max_speed_percent);
				end
				STEP_RIGHT: begin
					md_req.issue = 1'b1;
					md_req.a     = turn_q ? inner_q : thr9;
					md_req.b     = 16'(cfg.max_speed_percent);
				end
				STEP_LCMP, STEP_RCMP: begin
					md_req.issue = 1'b1;
					md_req.a     = rsp_val;
					md_req.b     = pm1;
				end
				default: ;
			endcase
		end
	end

	// Trip sums: clear first, then add positive speeds with saturation
	assign left_pos  = !left_q[8] && (|left_q);
	assign right_pos = !right_q[8] && (|right_q);
	assign lsum_base = clr_q ? 32'd0 : left_sum_q;
	assign rsum_base = clr_q ? 32'd0 : right_sum_q;
	assign lsum_add  = {1'b0, lsum_base} + 33'(left_q);
	assign rsum_add  = {1'b0, rsum_base} + 33'(right_q);
	assign lsum_next = !left_pos ? lsum_base :
		(lsum_add[32] ? 32'hFFFF_FFFF : lsum_add[31:0]);
	assign rsum_next = !right_pos ? rsum_base :
		(rsum_add[32] ? 32'hFFFF_FFFF : rsum_add[31:0]);
	assign trip_total = {1'b0, left_sum_q} + {1'b0, right_sum_q};

	assign out_free = !res_valid_q || res.ready;
	assign out_load = (state_q == ST_BUSY) && (step_q == STEP_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_INNER;
			left_sum_q  <= 32'd0;
			right_sum_q <= 32'd0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						state_q <= ST_BUSY;
						step_q  <= STEP_INNER;
					end
				end
				ST_BUSY: begin
					if (step_q != STEP_DONE) begin
						step_q <= 3'(step_q + 3'd1);
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if ((state_q == ST_BUSY) && (step_q == STEP_TRIP)) begin
				left_sum_q  <= lsum_next;
				right_sum_q <= rsum_next;
			end

			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Item payload and intermediate speeds
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			thr_q   <= cmd.throttle;
			turn_q  <= cmd.turn_right;
			clr_q   <= cmd.clear_trip;
			ratio_q <= dmpd_pkg::ratio_lookup(idx);
			servo_q <= 16'(cfg.servo_center_count - {{7{ang_bits[8]}}, ang_bits});
		end
		if (state_q == ST_BUSY) begin
			unique case (step_q)
				STEP_LEFT:  inner_q <= rsp_val;
				STEP_LCMP:  left_q  <= rsp_val;
				STEP_RCMP:  right_q <= rsp_val;
				STEP_TRIP:  lcmp_q  <= cmp_sat;
				default: ;
			endcase
		end
		if (out_load) begin
			res_lrev_q  <= left_q[8];
			res_lcmp_q  <= lcmp_q;
			res_rrev_q  <= right_q[8];
			res_rcmp_q  <= cmp_sat;
			res_servo_q <= servo_q;
			res_trip_q  <= trip_total[32:1];
		end
	end

	assign res.valid         = res_valid_q;
	assign res.left_reverse  = res_lrev_q;
	assign res.left_compare  = res_lcmp_q;
	assign res.right_reverse = res_rrev_q;
	assign res.right_compare = res_rcmp_q;
	assign res.servo_compare = res_servo_q;
	assign res.trip_distance = res_trip_q;

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past((state_q == ST_BUSY) && (step_q == STEP_DONE)))
		else $error("result valid rose outside the final step");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> ((state_q == ST_BUSY) && (step_q == STEP_INNER)))
		else $error("accepted item did not start the sequencer");

	a_trip_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_BUSY) && (step_q == STEP_TRIP) && !clr_q) |=>
		((left_sum_q >= $past(left_sum_q)) && (right_sum_q >= $past(right_sum_q))))
		else $error("trip sum decreased without a clear");

	a_trip_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!((state_q == ST_BUSY) && (step_q == STEP_TRIP)) |=>
		($stable(left_sum_q) && $stable(right_sum_q)))
		else $error("trip sum changed outside the trip step");

endmodule

`default_nettype wire

### hdl/dmpd_regs.sv
// ----------------------------------------------------------------------------
// dmpd_regs
// APB configuration registers: speed scale, PWM period, servo center.
// ----------------------------------------------------------------------------
`default_nettype none

module dmpd_regs (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [dmpd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	output dmpd_pkg::cfg_t                 cfg
);

	localparam logic [1:0] REG_MAX_SPEED    = 2'd0;
	localparam logic [1:0] REG_PWM_PERIOD   = 2'd1;
	localparam logic [1:0] REG_SERVO_CENTER = 2'd2;

	localparam logic [6:0]  RST_MAX_SPEED    = 7'd50;
	localparam logic [15:0] RST_PWM_PERIOD   = 16'd33332;
	localparam logic [15:0] RST_SERVO_CENTER = 16'd0;

	logic [1:0]     reg_sel;
	logic           wr_en;
	dmpd_pkg::cfg_t cfg_q;

	assign reg_sel = paddr[dmpd_pkg::ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed_percent  <= RST_MAX_SPEED;
			cfg_q.motor_pwm_period   <= RST_PWM_PERIOD;
			cfg_q.servo_center_count <= RST_SERVO_CENTER;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_MAX_SPEED:    cfg_q.max_speed_percent  <= pwdata[6:0];
				REG_PWM_PERIOD:   cfg_q.motor_pwm_period   <= pwdata[15:0];
				REG_SERVO_CENTER: cfg_q.servo_center_count <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MAX_SPEED:    prdata = 32'(cfg_q.max_speed_percent);
			REG_PWM_PERIOD:   prdata = 32'(cfg_q.motor_pwm_period);
			REG_SERVO_CENTER: prdata = 32'(cfg_q.servo_center_count);
			default:          prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

### hdl/dmpd_muldiv.sv
// ----------------------------------------------------------------------------
// dmpd_muldiv
// Shared two-stage unit: |a| * b, then truncating divide by 100 through a
// reciprocal multiply. Sign of a travels alongside the magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module dmpd_muldiv (
	input  wire logic              clk,
	input  wire dmpd_pkg::md_req_t req,
	output dmpd_pkg::md_rsp_t      rsp
);

	logic [8:0]                      mag;
	logic [24:0]                     prod_full;
	logic [dmpd_pkg::PROD_W-1:0]     prod_s1;
	logic                            neg_s1;
	logic [48:0]                     scaled;
	logic [dmpd_pkg::QUOT_W-1:0]     quot_s2;
	logic                            neg_s2;

	assign mag       = req.a[8] ? 9'(-req.a) : req.a;
	assign prod_full = 25'(mag) * 25'(req.b);

	// Stage 1 loads only on issue, so an idle unit keeps its last answer
	always_ff @(posedge clk) begin
		if (req.issue) begin
			prod_s1 <= prod_full[dmpd_pkg::PROD_W-1:0];
			neg_s1  <= req.a[8];
		end
	end

	assign scaled = 49'(prod_s1) * 49'(dmpd_pkg::DIV100_MUL);

	always_ff @(posedge clk) begin
		quot_s2 <= scaled[dmpd_pkg::DIV100_SHIFT +: dmpd_pkg::QUOT_W];
		neg_s2  <= neg_s1;
	end

	assign rsp.neg  = neg_s2;
	assign rsp.quot = quot_s2;

endmodule

`default_nettype wire
